/* sv/blr_pkg.sv */
// Shared types and constants of the Bresenham line rasterizer.
package blr_pkg;

  // Width of the window bound registers.
  localparam int unsigned WinBits = 13;

  // Register reset values.
  localparam logic [WinBits-1:0] WinWidthReset  = 13'd640;
  localparam logic [WinBits-1:0] WinHeightReset = 13'd480;

  // Configuration register indexes.
  typedef enum logic {
    REG_WINDOW_WIDTH  = 1'b0,
    REG_WINDOW_HEIGHT = 1'b1
  } blr_reg_e;

  // Input beat kinds.
  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_STEP = 1'b1
  } blr_cmd_e;

endpackage

/* sv/blr_in_stage.sv */
// Input register of the line rasterizer: captures one beat and holds it until consumed.
module blr_in_stage import blr_pkg::*; #(
  parameter int unsigned COORD_BITS = 14
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  blr_cmd_e                     cmd_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  output logic                         valid_o,
  input  logic                         take_i,
  output blr_cmd_e                     cmd_o,
  output logic signed [COORD_BITS-1:0] start_x_o,
  output logic signed [COORD_BITS-1:0] start_y_o,
  output logic signed [COORD_BITS-1:0] end_x_o,
  output logic signed [COORD_BITS-1:0] end_y_o
);

  logic                         valid_q;
  blr_cmd_e                     cmd_q;
  logic signed [COORD_BITS-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
  logic                         load_en;

  // The register is free when empty or when its beat leaves this cycle.
  assign ready_o = !valid_q || take_i;
  assign load_en = valid_i && ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_en) begin
      cmd_q     <= cmd_i;
      start_x_q <= start_x_i;
      start_y_q <= start_y_i;
      end_x_q   <= end_x_i;
      end_y_q   <= end_y_i;
    end
  end

  assign valid_o   = valid_q;
  assign cmd_o     = cmd_q;
  assign start_x_o = start_x_q;
  assign start_y_o = start_y_q;
  assign end_x_o   = end_x_q;
  assign end_y_o   = end_y_q;

endmodule

/* sv/blr_core.sv */
// Line state, per-beat setup and step logic, and the pixel output register.
module blr_core import blr_pkg::*; #(
  parameter int unsigned COORD_BITS = 14
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [WinBits-1:0]           win_width_i,
  input  logic [WinBits-1:0]           win_height_i,
  input  logic                         valid_i,
  output logic                         take_o,
  input  blr_cmd_e                     cmd_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [COORD_BITS-1:0] pixel_x_o,
  output logic signed [COORD_BITS-1:0] pixel_y_o,
  output logic                         inside_window_o,
  output logic                         last_o
);

  localparam int unsigned DW = COORD_BITS + 1;  // delta and step count
  localparam int unsigned TW = COORD_BITS + 2;  // doubled delta
  localparam int unsigned EW = COORD_BITS + 3;  // error term
  localparam int unsigned CW = (COORD_BITS > WinBits) ? COORD_BITS : WinBits;

  // Line state.
  logic                         active_q;
  logic signed [COORD_BITS-1:0] cur_x_q, cur_y_q;
  logic signed [EW-1:0]         err_q;
  logic [DW-1:0]                steps_q;
  logic                         x_neg_q, y_neg_q, x_major_q;
  logic [TW-1:0]                twice_dx_q, twice_dy_q;

  // Output register.
  logic                         out_valid_q;
  logic signed [COORD_BITS-1:0] pixel_x_q, pixel_y_q;
  logic                         inside_q, last_q;

  logic                         out_free;
  logic                         do_load, do_step;

  // Setup terms.
  logic signed [DW-1:0]         dx, dy;
  logic [DW-1:0]                adx, ady;
  logic                         maj_x;
  logic [TW-1:0]                tdx, tdy;
  logic signed [EW-1:0]         err_init;

  // Step terms.
  logic signed [COORD_BITS-1:0] x_inc, y_inc;
  logic signed [EW-1:0]         t_minor, t_major, err_hold, err_move;
  logic                         err_le0, fin, in_win;
  logic [CW-1:0]                x_mag, y_mag;

  assign out_free = !out_valid_q || out_ready_i;
  // A step on an active line needs room in the output register; other beats never wait.
  assign take_o   = valid_i && (cmd_i == CMD_LOAD || !active_q || out_free);
  assign do_load  = take_o && cmd_i == CMD_LOAD;
  assign do_step  = take_o && cmd_i == CMD_STEP && active_q;

  always_comb begin
    dx       = DW'(end_x_i) - DW'(start_x_i);
    dy       = DW'(end_y_i) - DW'(start_y_i);
    adx      = dx[DW-1] ? DW'(-dx) : DW'(dx);
    ady      = dy[DW-1] ? DW'(-dy) : DW'(dy);
    maj_x    = ady <= adx;
    tdx      = {1'b0, adx[DW-2:0], 1'b0};
    tdy      = {1'b0, ady[DW-2:0], 1'b0};
    err_init = maj_x ? (EW'(tdy) - EW'(adx)) : (EW'(tdx) - EW'(ady));
  end

  always_comb begin
    x_inc    = x_neg_q ? COORD_BITS'(-1) : COORD_BITS'(1);
    y_inc    = y_neg_q ? COORD_BITS'(-1) : COORD_BITS'(1);
    t_minor  = x_major_q ? EW'(twice_dy_q) : EW'(twice_dx_q);
    t_major  = x_major_q ? EW'(twice_dx_q) : EW'(twice_dy_q);
    err_le0  = err_q[EW-1] || (err_q == '0);
    err_hold = err_q + t_minor;
    err_move = err_q + (t_minor - t_major);
    fin      = (steps_q == '0);
    x_mag    = CW'(cur_x_q[COORD_BITS-2:0]);
    y_mag    = CW'(cur_y_q[COORD_BITS-2:0]);
    in_win   = !cur_x_q[COORD_BITS-1] && (x_mag <= CW'(win_width_i)) &&
               !cur_y_q[COORD_BITS-1] && (y_mag <= CW'(win_height_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
    end else if (do_load) begin
      active_q <= 1'b1;
    end else if (do_step && fin) begin
      active_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_load) begin
      cur_x_q    <= start_x_i;
      cur_y_q    <= start_y_i;
      err_q      <= err_init;
      steps_q    <= maj_x ? adx : ady;
      x_neg_q    <= dx[DW-1];
      y_neg_q    <= dy[DW-1];
      x_major_q  <= maj_x;
      twice_dx_q <= tdx;
      twice_dy_q <= tdy;
    end else if (do_step) begin
      err_q   <= err_le0 ? err_hold : err_move;
      steps_q <= steps_q - DW'(1);
      if (x_major_q || !err_le0) begin
        cur_x_q <= cur_x_q + x_inc;
      end
      if (!x_major_q || !err_le0) begin
        cur_y_q <= cur_y_q + y_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (do_step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_step) begin
      pixel_x_q <= cur_x_q;
      pixel_y_q <= cur_y_q;
      inside_q  <= in_win;
      last_q    <= fin;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign pixel_x_o       = pixel_x_q;
  assign pixel_y_o       = pixel_y_q;
  assign inside_window_o = inside_q;
  assign last_o          = last_q;

endmodule

/* sv/bresenham_line_rasterizer.sv */
// Top level of the Bresenham line rasterizer: ports, window registers and the two stages.
//
//   Channel  Direction  Handshake                    Payload
//   s_axis   in         s_axis_tvalid/s_axis_tready  tuser = cmd, tdata = endpoints
//   m_axis   out        m_axis_tvalid/m_axis_tready  tdata = pixel, tuser/tlast = flags
//   cfg      in         cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// Every beat is captured in the input register and resolved from there by the core,
// so the block takes one beat per clock while no step waits on a stalled output; a
// pixel passes the input register and then the pixel register before it reaches m_axis.
// The rate is set by the update of the error term and the current point, which each
// step feeds to the next.
// Reset clears the line state to idle and the window to 640 by 480.
// A stalled output holds the pixel register; only steps on an active line then wait,
// and the stall reaches s_axis_tready through the input register.
module bresenham_line_rasterizer import blr_pkg::*; #(
  parameter int unsigned COORD_BITS = 14
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // Input stream.
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // tuser: cmd (0 = load endpoints, 1 = step one pixel).
  input  logic                                     s_axis_tuser,
  // tdata from bit 0 up: start_x, start_y, end_x, end_y, zero padding.
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]        s_axis_tdata,
  // Output stream.
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // tdata from bit 0 up: pixel_x, pixel_y, zero padding.
  output logic [((2*COORD_BITS+7)/8)*8-1:0]        m_axis_tdata,
  // tuser: inside_window.
  output logic                                     m_axis_tuser,
  // tlast: last pixel of the line.
  output logic                                     m_axis_tlast,
  // Configuration writes.
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic                                     cfg_index_i,
  input  logic [WinBits-1:0]                       cfg_data_i
);

  localparam int unsigned ODataW = ((2*COORD_BITS+7)/8)*8;

  logic [WinBits-1:0]           win_width_q, win_height_q;
  logic                         cfg_we;

  logic                         st_valid, st_take;
  blr_cmd_e                     st_cmd;
  logic signed [COORD_BITS-1:0] st_start_x, st_start_y, st_end_x, st_end_y;

  logic signed [COORD_BITS-1:0] pixel_x, pixel_y;

  // The window registers take a write in any cycle.
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_width_q  <= WinWidthReset;
      win_height_q <= WinHeightReset;
    end else if (cfg_we) begin
      case (blr_reg_e'(cfg_index_i))
        REG_WINDOW_WIDTH:  win_width_q  <= cfg_data_i;
        REG_WINDOW_HEIGHT: win_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register: decouples the upstream handshake from the step logic.
  blr_in_stage #(
    .COORD_BITS(COORD_BITS)
  ) u_in_stage (
    .clk_i,
    .rst_ni,
    .valid_i   (s_axis_tvalid),
    .ready_o   (s_axis_tready),
    .cmd_i     (blr_cmd_e'(s_axis_tuser)),
    .start_x_i (s_axis_tdata[COORD_BITS-1:0]),
    .start_y_i (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .end_x_i   (s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .end_y_i   (s_axis_tdata[4*COORD_BITS-1:3*COORD_BITS]),
    .valid_o   (st_valid),
    .take_i    (st_take),
    .cmd_o     (st_cmd),
    .start_x_o (st_start_x),
    .start_y_o (st_start_y),
    .end_x_o   (st_end_x),
    .end_y_o   (st_end_y)
  );

  // Line setup on a load, one pixel and one error update on a step.
  blr_core #(
    .COORD_BITS(COORD_BITS)
  ) u_core (
    .clk_i,
    .rst_ni,
    .win_width_i     (win_width_q),
    .win_height_i    (win_height_q),
    .valid_i         (st_valid),
    .take_o          (st_take),
    .cmd_i           (st_cmd),
    .start_x_i       (st_start_x),
    .start_y_i       (st_start_y),
    .end_x_i         (st_end_x),
    .end_y_i         (st_end_y),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .pixel_x_o       (pixel_x),
    .pixel_y_o       (pixel_y),
    .inside_window_o (m_axis_tuser),
    .last_o          (m_axis_tlast)
  );

  assign m_axis_tdata = ODataW'({pixel_y, pixel_x});

endmodule
